### rtl/core/scc_pkg.sv
// Shared types and constants for the strongly connected components block.
// Used by scc_ctrl, scc_dpath and the top level strongly_connected_components.
`default_nettype none

package scc_pkg;

    // Vertex numbers are 6-bit fields, so a graph holds at most 64 vertices
    localparam int VTX_W    = 6;
    localparam int NUM_VTX  = 64;
    localparam int CNT_W    = 7;     // holds 0..NUM_VTX
    localparam int MAX_EDGES_DEF = 1024;

    // Command codes carried on the input item's tuser
    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Datapath commands issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_F_INIT,
        OP_F_SKIP,
        OP_F_ROOT,
        OP_F_READ,
        OP_F_PUSH,
        OP_F_ADV,
        OP_F_FIN_ROOT,
        OP_F_FIN_POP,
        OP_POP_LOAD,
        OP_R_INIT,
        OP_R_READFIN,
        OP_R_ROOT,
        OP_R_READ,
        OP_R_PUSH,
        OP_R_FIN_ROOT,
        OP_R_FIN_POP,
        OP_E_INIT,
        OP_E_READ,
        OP_E_LOAD,
        OP_E_NEXT
    } t_op;

    // Datapath status seen by the controller
    typedef struct packed {
        logic start_end;
        logic start_vis;
        logic k_end;
        logic k_zero;
        logic fwd_hit;
        logic rev_hit;
        logic psp_zero;
        logic fin_zero;
        logic take_skip;
        logic emit_last;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

### rtl/core/scc_dpath.sv
// Datapath: edge store, search and finish stacks, visited marks, labels, output register.
// Executes one scc_pkg::t_op command per cycle; depends on scc_pkg.
`default_nettype none

module scc_dpath #(
    parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  scc_pkg::t_op                i_op,
    input  wire [scc_pkg::VTX_W-1:0]    i_src,
    input  wire [scc_pkg::VTX_W-1:0]    i_tgt,
    input  wire                         i_cfg_we,
    input  wire [scc_pkg::VTX_W-1:0]    i_cfg_wdata,
    input  wire                         i_m_tready,
    output scc_pkg::t_status            o_status,
    output logic                        o_m_tvalid,
    output logic [23:0]                 o_m_tdata,
    output logic                        o_m_tlast
);
    import scc_pkg::*;

    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int VI_W = $clog2(NUM_VTX);
    localparam int FR_W = VTX_W + EC_W;

    // Storage
    logic [2*VTX_W-1:0] edge_mem [MAX_EDGES];
    logic [FR_W-1:0]    stk_mem  [NUM_VTX];
    logic [VTX_W-1:0]   fin_mem  [NUM_VTX];
    logic [VTX_W-1:0]   comp_mem [NUM_VTX];

    logic [2*VTX_W-1:0] r_edge_q;
    logic [FR_W-1:0]    r_stk_q;
    logic [VTX_W-1:0]   r_fin_q;
    logic [VTX_W-1:0]   r_comp_q;

    logic [EC_W-1:0]    r_edge_cnt;
    logic               r_ovf;
    logic [VTX_W-1:0]   r_hv;
    logic [NUM_VTX-1:0] r_vis;
    logic [CNT_W-1:0]   r_start;
    logic [CNT_W-1:0]   r_fin;
    logic [CNT_W-1:0]   r_psp;
    logic [CNT_W-1:0]   r_cc;
    logic [VTX_W-1:0]   r_u;
    logic [EC_W-1:0]    r_k;
    logic [VTX_W-1:0]   r_ov;
    logic               r_out_valid;
    logic [23:0]        r_out_data;
    logic               r_out_last;

    logic [CNT_W-1:0]   nv;
    logic [VTX_W-1:0]   e_src;
    logic [VTX_W-1:0]   e_dst;
    logic [VTX_W-1:0]   stk_u;
    logic [EC_W-1:0]    stk_k;
    logic               stk_we;
    logic [FR_W-1:0]    stk_wd;
    logic               comp_we;
    logic [VTX_W-1:0]   comp_wa;

    assign nv    = {1'b0, r_hv} + CNT_W'(1);
    assign e_src = r_edge_q[2*VTX_W-1:VTX_W];
    assign e_dst = r_edge_q[VTX_W-1:0];
    assign stk_u = r_stk_q[FR_W-1:EC_W];
    assign stk_k = r_stk_q[EC_W-1:0];

    // Status toward the controller
    always_comb begin
        o_status.start_end = (r_start == nv);
        o_status.start_vis = r_vis[r_start[VI_W-1:0]];
        o_status.k_end     = (r_k == r_edge_cnt);
        o_status.k_zero    = (r_k == '0);
        o_status.fwd_hit   = (e_src == r_u) && ({1'b0, e_dst} < nv) && !r_vis[e_dst];
        o_status.rev_hit   = (e_dst == r_u) && ({1'b0, e_src} < nv) && !r_vis[e_src];
        o_status.psp_zero  = (r_psp == '0);
        o_status.fin_zero  = (r_fin == '0);
        o_status.take_skip = !({1'b0, r_fin_q} < nv) || r_vis[r_fin_q];
        o_status.emit_last = ({1'b0, r_ov} == nv - CNT_W'(1));
        o_status.out_busy  = r_out_valid;
    end

    // Edge store: one write port for loads, one registered read for the searches
    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD && r_edge_cnt < EC_W'(MAX_EDGES)) begin
            edge_mem[r_edge_cnt[EA_W-1:0]] <= {i_src, i_tgt};
        end
        if (i_op == OP_F_READ) begin
            r_edge_q <= edge_mem[r_k[EA_W-1:0]];
        end else if (i_op == OP_R_READ) begin
            r_edge_q <= edge_mem[EA_W'(r_k - EC_W'(1))];
        end
    end

    // Search stack holds the frames below the top one
    assign stk_we = (i_op == OP_F_PUSH) || (i_op == OP_R_PUSH);
    assign stk_wd = (i_op == OP_F_PUSH) ? {r_u, r_k + EC_W'(1)} : {r_u, r_k};

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[r_psp[VI_W-1:0]] <= stk_wd;
        end
        if (i_op == OP_F_FIN_POP || i_op == OP_R_FIN_POP) begin
            r_stk_q <= stk_mem[VI_W'(r_psp - CNT_W'(1))];
        end
    end

    // Finish-order stack
    always_ff @(posedge i_clk) begin
        if (i_op == OP_F_FIN_ROOT || i_op == OP_F_FIN_POP) begin
            fin_mem[r_fin[VI_W-1:0]] <= r_u;
        end
        if (i_op == OP_R_READFIN) begin
            r_fin_q <= fin_mem[VI_W'(r_fin - CNT_W'(1))];
        end
    end

    // Component labels
    assign comp_we = (i_op == OP_R_ROOT) || (i_op == OP_R_PUSH);
    assign comp_wa = (i_op == OP_R_ROOT) ? r_fin_q : e_src;

    always_ff @(posedge i_clk) begin
        if (comp_we) begin
            comp_mem[comp_wa] <= VTX_W'(r_cc);
        end
        if (i_op == OP_E_READ) begin
            r_comp_q <= comp_mem[r_ov];
        end
    end

    // Control counters, marks and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt  <= '0;
            r_ovf       <= 1'b0;
            r_hv        <= VTX_W'(NUM_VTX - 1);
            r_vis       <= '0;
            r_start     <= '0;
            r_fin       <= '0;
            r_psp       <= '0;
            r_cc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hv <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (i_op)
                OP_LOAD: begin
                    if (r_edge_cnt < EC_W'(MAX_EDGES)) begin
                        r_edge_cnt <= r_edge_cnt + EC_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                OP_CLEAR: begin
                    r_edge_cnt <= '0;
                    r_ovf      <= 1'b0;
                end
                OP_F_INIT: begin
                    r_vis   <= '0;
                    r_start <= '0;
                    r_fin   <= '0;
                end
                OP_F_SKIP: r_start <= r_start + CNT_W'(1);
                OP_F_ROOT: begin
                    r_vis[r_start[VI_W-1:0]] <= 1'b1;
                    r_u   <= r_start[VTX_W-1:0];
                    r_k   <= '0;
                    r_psp <= '0;
                end
                OP_F_PUSH: begin
                    r_psp        <= r_psp + CNT_W'(1);
                    r_vis[e_dst] <= 1'b1;
                    r_u          <= e_dst;
                    r_k          <= '0;
                end
                OP_F_ADV: r_k <= r_k + EC_W'(1);
                OP_F_FIN_ROOT: begin
                    r_fin   <= r_fin + CNT_W'(1);
                    r_start <= r_start + CNT_W'(1);
                end
                OP_F_FIN_POP: begin
                    r_fin <= r_fin + CNT_W'(1);
                    r_psp <= r_psp - CNT_W'(1);
                end
                OP_POP_LOAD: begin
                    r_u <= stk_u;
                    r_k <= stk_k;
                end
                OP_R_INIT: begin
                    r_vis <= '0;
                    r_cc  <= '0;
                end
                OP_R_READFIN: r_fin <= r_fin - CNT_W'(1);
                OP_R_ROOT: begin
                    r_vis[r_fin_q] <= 1'b1;
                    r_u   <= r_fin_q;
                    r_k   <= r_edge_cnt;
                    r_psp <= '0;
                end
                OP_R_READ: r_k <= r_k - EC_W'(1);
                OP_R_PUSH: begin
                    r_psp        <= r_psp + CNT_W'(1);
                    r_vis[e_src] <= 1'b1;
                    r_u          <= e_src;
                    r_k          <= r_edge_cnt;
                end
                OP_R_FIN_ROOT: r_cc  <= r_cc + CNT_W'(1);
                OP_R_FIN_POP:  r_psp <= r_psp - CNT_W'(1);
                OP_E_LOAD:     r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Emit cursor and output payload
    always_ff @(posedge i_clk) begin
        if (i_op == OP_E_INIT) begin
            r_ov <= '0;
        end else if (i_op == OP_E_NEXT) begin
            r_ov <= r_ov + VTX_W'(1);
        end
        if (i_op == OP_E_LOAD) begin
            r_out_data <= {4'd0, r_ovf, r_cc, r_comp_q, r_ov};
            r_out_last <= o_status.emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // Stacks and counters stay within the vertex count; the edge count stays within MAX_EDGES
    a_fin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin <= CNT_W'(NUM_VTX)) else $error("finish stack overrun");
    a_psp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_psp < CNT_W'(NUM_VTX)) else $error("search stack overrun");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_cnt <= EC_W'(MAX_EDGES)) else $error("edge count overrun");
    a_cc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc <= CNT_W'(NUM_VTX)) else $error("component count overrun");

endmodule

`default_nettype wire

### rtl/core/scc_ctrl.sv
// Controller: sequences loads, the two depth-first passes and the result emission.
// Issues scc_pkg::t_op commands to scc_dpath and reads its t_status.
`default_nettype none

module scc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    input  scc_pkg::t_action    i_action,
    input  scc_pkg::t_status    i_status,
    output logic                o_s_tready,
    output scc_pkg::t_op        o_op
);
    import scc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_F_INIT, S_F_START, S_F_RD, S_F_CHK, S_F_FIN, S_F_POP,
        S_R_INIT, S_R_NEXT, S_R_TAKE, S_R_RD, S_R_CHK, S_R_FIN, S_R_POP,
        S_E_RD, S_E_LOAD, S_E_WAIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    // Pick the command and next state
    always_comb begin
        o_op    = OP_NONE;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (i_action)
                        ACT_LOAD:  o_op = OP_LOAD;
                        ACT_CLEAR: o_op = OP_CLEAR;
                        ACT_RUN:   n_state = S_F_INIT;
                        default: ;
                    endcase
                end
            end
            S_F_INIT: begin
                o_op    = OP_F_INIT;
                n_state = S_F_START;
            end
            S_F_START: begin
                if (i_status.start_end) begin
                    n_state = S_R_INIT;
                end else if (i_status.start_vis) begin
                    o_op = OP_F_SKIP;
                end else begin
                    o_op    = OP_F_ROOT;
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                if (i_status.k_end) begin
                    n_state = S_F_FIN;
                end else begin
                    o_op    = OP_F_READ;
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                o_op    = i_status.fwd_hit ? OP_F_PUSH : OP_F_ADV;
                n_state = S_F_RD;
            end
            S_F_FIN: begin
                if (i_status.psp_zero) begin
                    o_op    = OP_F_FIN_ROOT;
                    n_state = S_F_START;
                end else begin
                    o_op    = OP_F_FIN_POP;
                    n_state = S_F_POP;
                end
            end
            S_F_POP: begin
                o_op    = OP_POP_LOAD;
                n_state = S_F_RD;
            end
            S_R_INIT: begin
                o_op    = OP_R_INIT;
                n_state = S_R_NEXT;
            end
            S_R_NEXT: begin
                if (i_status.fin_zero) begin
                    o_op    = OP_E_INIT;
                    n_state = S_E_RD;
                end else begin
                    o_op    = OP_R_READFIN;
                    n_state = S_R_TAKE;
                end
            end
            S_R_TAKE: begin
                if (i_status.take_skip) begin
                    n_state = S_R_NEXT;
                end else begin
                    o_op    = OP_R_ROOT;
                    n_state = S_R_RD;
                end
            end
            S_R_RD: begin
                if (i_status.k_zero) begin
                    n_state = S_R_FIN;
                end else begin
                    o_op    = OP_R_READ;
                    n_state = S_R_CHK;
                end
            end
            S_R_CHK: begin
                if (i_status.rev_hit) begin
                    o_op = OP_R_PUSH;
                end
                n_state = S_R_RD;
            end
            S_R_FIN: begin
                if (i_status.psp_zero) begin
                    o_op    = OP_R_FIN_ROOT;
                    n_state = S_R_NEXT;
                end else begin
                    o_op    = OP_R_FIN_POP;
                    n_state = S_R_POP;
                end
            end
            S_R_POP: begin
                o_op    = OP_POP_LOAD;
                n_state = S_R_RD;
            end
            S_E_RD: begin
                o_op    = OP_E_READ;
                n_state = S_E_LOAD;
            end
            S_E_LOAD: begin
                o_op    = OP_E_LOAD;
                n_state = S_E_WAIT;
            end
            S_E_WAIT: begin
                if (!i_status.out_busy) begin
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_op    = OP_E_NEXT;
                        n_state = S_E_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Inputs are taken only while idle; emission leaves only after the last item
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (o_op == OP_NONE || o_op == OP_LOAD || o_op == OP_CLEAR))
        else $error("command issued while idle without load or clear");
    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_WAIT && n_state == S_IDLE) |-> i_status.emit_last)
        else $error("emission ended before the last vertex");
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F_INIT) |-> $past(r_state == S_IDLE))
        else $error("run started from a busy state");

endmodule

`default_nettype wire

### rtl/core/strongly_connected_components.sv
// Strongly connected components of a directed graph, two-pass depth-first search.
//
// Input channel (s_axis): tuser carries the command (load edge, run, clear);
// tdata carries the edge's source and target vertex. Loads and clears return
// nothing, so edges stream in at one item a cycle while the block is idle.
// A run blocks the input channel until its last result has been taken.
// Output channel (m_axis): one item per vertex 0..highest_vertex with its
// component, the component total and the dropped-edge flag; tlast marks the
// highest vertex. The run time is set by the edge scans through the single
// edge memory read port: every vertex scans the whole edge list in each pass;
// then each emitted item passes through S_E_RD, S_E_LOAD and S_E_WAIT,
// where it waits out any receiver stall. A stalled receiver holds the
// output item and the run waits.
// Configuration: i_cfg_we writes highest_vertex; the user must write it only while the block is idle (not enforced).
// Reset (synchronous, active low) empties the edge store, clears the flag and
// sets highest_vertex to 63; no clearing pass is needed.
// Depends on scc_pkg, scc_ctrl and scc_dpath.
`default_nettype none

module strongly_connected_components #(
    parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [15:0]  i_s_axis_tdata,  // [5:0] edge_source, [11:6] edge_target
    input  wire [1:0]   i_s_axis_tuser,  // [1:0] action
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [5:0] vertex, [11:6] component,
                                         // [18:12] component_total, [19] edges_dropped
    output logic        o_m_axis_tlast,  // last
    input  wire         i_cfg_we,
    input  wire [5:0]   i_cfg_wdata      // highest_vertex
);
    import scc_pkg::*;

    t_op     op;
    t_status status;
    t_action action;

    assign action = t_action'(i_s_axis_tuser);

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_action   (action),
        .i_status   (status),
        .o_s_tready (o_s_axis_tready),
        .o_op       (op)
    );

    scc_dpath #(
        .MAX_EDGES (MAX_EDGES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_src       (i_s_axis_tdata[5:0]),
        .i_tgt       (i_s_axis_tdata[11:6]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_axis_tready),
        .o_status    (status),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule

`default_nettype wire
